// ===== rtl/fat12_cluster_chain_walker_macros.svh =====
// Assertion macros for the FAT12 cluster chain walker.
// Uses clk and rst_n of the module that includes this header.
`ifndef FAT12_CLUSTER_CHAIN_WALKER_MACROS_SVH
`define FAT12_CLUSTER_CHAIN_WALKER_MACROS_SVH
`ifndef SYNTHESIS
`define FCW_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fcw assertion failed");
`define FCW_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fcw assertion failed");
`else
`define FCW_ASSERT_IMPL(label, ante, cons)
`define FCW_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== rtl/fcw_pkg.sv =====
// Shared types, constants and the control store of the FAT12 chain walker.
// No dependencies.
`default_nettype none
package fcw_pkg;

    localparam int FAT_BYTES = 8192;
    localparam int MAX_CHAIN = 64;
    localparam int FAT_AW    = $clog2(FAT_BYTES);
    localparam int CNT_W     = (MAX_CHAIN > 1) ? $clog2(MAX_CHAIN) : 1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_BAD   = 2'd2;
    localparam logic [1:0] ST_LONG  = 2'd3;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_WALK  = 1'b1;

    localparam logic [1:0] REG_DATA_START = 2'd0;
    localparam logic [1:0] REG_SPC        = 2'd1;
    localparam logic [1:0] REG_END_THR    = 2'd2;

    localparam logic [11:0] FIRST_DATA_CLUSTER = 12'd2;

    typedef struct packed {
        logic        operation;
        logic [12:0] fat_address;
        logic [7:0]  fat_byte;
        logic [11:0] start_cluster;
    } item_t;

    typedef struct packed {
        logic [11:0] cluster;
        logic [23:0] sector_lba;
        logic        last;
        logic [1:0]  status;
    } result_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EMPTY,
        S_BAD,
        S_LO,
        S_LINK
    } step_t;

    typedef enum logic [2:0] {
        BR_INPUT,
        BR_EMPTY,
        BR_BAD,
        BR_NEXT,
        BR_LINK
    } branch_t;

    typedef struct packed {
        logic    rd_en;
        logic    rd_hi;
        logic    cap_lo;
        branch_t branch;
        step_t   target;
    } ctrl_t;

    // Control store: one word per step.
    function automatic ctrl_t ucode_rom(input step_t step);
        ctrl_t w;
        w = '{rd_en: 1'b0, rd_hi: 1'b0, cap_lo: 1'b0, branch: BR_INPUT, target: S_IDLE};
        case (step)
            S_IDLE:  w = '{rd_en: 1'b0, rd_hi: 1'b0, cap_lo: 1'b0,
                           branch: BR_INPUT, target: S_EMPTY};
            S_EMPTY: w = '{rd_en: 1'b0, rd_hi: 1'b0, cap_lo: 1'b0,
                           branch: BR_EMPTY, target: S_BAD};
            S_BAD:   w = '{rd_en: 1'b1, rd_hi: 1'b0, cap_lo: 1'b0,
                           branch: BR_BAD, target: S_LO};
            S_LO:    w = '{rd_en: 1'b1, rd_hi: 1'b1, cap_lo: 1'b1,
                           branch: BR_NEXT, target: S_LINK};
            S_LINK:  w = '{rd_en: 1'b0, rd_hi: 1'b0, cap_lo: 1'b0,
                           branch: BR_LINK, target: S_BAD};
            default: w = '{rd_en: 1'b0, rd_hi: 1'b0, cap_lo: 1'b0,
                           branch: BR_INPUT, target: S_IDLE};
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/fat12_cluster_chain_walker.sv =====
// FAT12 cluster chain walker: FAT byte store, microcoded walk sequencer, APB registers.
// Depends on fcw_pkg and fat12_cluster_chain_walker_macros.svh.
`default_nettype none
`include "fat12_cluster_chain_walker_macros.svh"

// A write item stores one FAT byte and leaves the sequencer idle. A walk item first
// checks the start cluster against the end threshold; then, for each cluster of the
// chain, it checks for a bad cluster while reading the entry's low byte, reads the
// high byte and takes the link decision, one result per cluster. Items are taken one
// at a time; the result register lets the next item in while the last result waits.
// The FAT memory has no reset: only entries that were written may be walked.
module fat12_cluster_chain_walker (
    input  wire  logic            clk,
    input  wire  logic            rst_n,
    input  wire  logic            item_valid,
    output       logic            item_ready,
    input  wire  fcw_pkg::item_t  item,
    output       logic            result_valid,
    input  wire  logic            result_ready,
    output       fcw_pkg::result_t result,
    input  wire  logic            psel,
    input  wire  logic            penable,
    input  wire  logic            pwrite,
    input  wire  logic [3:0]      paddr,
    input  wire  logic [31:0]     pwdata,
    output       logic [31:0]     prdata,
    output       logic            pready
);

    // Configuration registers.
    logic [15:0] data_start_reg;
    logic [7:0]  spc_reg;
    logic [11:0] end_thr_reg;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_start_reg <= 16'd33;
            spc_reg        <= 8'd1;
            end_thr_reg    <= 12'd4088;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                fcw_pkg::REG_DATA_START: data_start_reg <= pwdata[15:0];
                fcw_pkg::REG_SPC:        spc_reg        <= pwdata[7:0];
                fcw_pkg::REG_END_THR:    end_thr_reg    <= pwdata[11:0];
                default:                 ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            fcw_pkg::REG_DATA_START: prdata = {16'd0, data_start_reg};
            fcw_pkg::REG_SPC:        prdata = {24'd0, spc_reg};
            fcw_pkg::REG_END_THR:    prdata = {20'd0, end_thr_reg};
            default:                 prdata = 32'd0;
        endcase
    end

    // Sequencer and datapath registers.
    fcw_pkg::step_t               step_reg, step_next;
    fcw_pkg::ctrl_t               ctrl;
    logic [11:0]                  cur_reg, cur_next;
    logic [fcw_pkg::CNT_W-1:0]    cnt_reg, cnt_next;
    logic [7:0]                   lo_reg;
    logic [19:0]                  prod_reg;
    logic [7:0]                   rd_data_reg;
    logic                         out_valid_reg, out_valid_next;
    fcw_pkg::result_t             out_reg, out_next;

    logic [7:0]                   fat_mem [fcw_pkg::FAT_BYTES];
    logic [fcw_pkg::FAT_AW-1:0]   entry_addr;
    logic [fcw_pkg::FAT_AW-1:0]   rd_addr;
    logic                         item_fire;
    logic                         slot_free;
    logic                         emit;
    logic [11:0]                  next_cl;
    logic [15:0]                  pair;
    logic [23:0]                  lba;

    assign ctrl       = fcw_pkg::ucode_rom(step_reg);
    assign item_ready = (step_reg == fcw_pkg::S_IDLE);
    assign item_fire  = item_valid && item_ready;
    assign slot_free  = !out_valid_reg || result_ready;

    // Entry of cluster c starts at byte c + c/2.
    assign entry_addr = fcw_pkg::FAT_AW'(cur_reg) + fcw_pkg::FAT_AW'(cur_reg[11:1]);
    assign rd_addr    = ctrl.rd_hi ? entry_addr + fcw_pkg::FAT_AW'(1) : entry_addr;

    always_ff @(posedge clk)
    begin
        if (item_fire && item.operation == fcw_pkg::OP_WRITE)
        begin
            fat_mem[item.fat_address[fcw_pkg::FAT_AW-1:0]] <= item.fat_byte;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.rd_en)
        begin
            rd_data_reg <= fat_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= 20'(cur_reg - fcw_pkg::FIRST_DATA_CLUSTER) * 20'(spc_reg);
        if (ctrl.cap_lo)
        begin
            lo_reg <= rd_data_reg;
        end
    end

    assign pair    = {rd_data_reg, lo_reg};
    assign next_cl = cur_reg[0] ? pair[15:4] : pair[11:0];
    assign lba     = 24'(data_start_reg) + 24'(prod_reg);

    always_comb
    begin
        step_next = step_reg;
        cur_next  = cur_reg;
        cnt_next  = cnt_reg;
        emit      = 1'b0;
        out_next  = out_reg;
        case (ctrl.branch)
            fcw_pkg::BR_INPUT:
            begin
                if (item_fire && item.operation == fcw_pkg::OP_WALK)
                begin
                    cur_next  = item.start_cluster;
                    cnt_next  = '0;
                    step_next = ctrl.target;
                end
            end
            fcw_pkg::BR_EMPTY:
            begin
                if (cur_reg >= end_thr_reg)
                begin
                    out_next = '{cluster: cur_reg, sector_lba: 24'd0, last: 1'b1,
                                 status: fcw_pkg::ST_EMPTY};
                    if (slot_free)
                    begin
                        emit      = 1'b1;
                        step_next = fcw_pkg::S_IDLE;
                    end
                end
                else
                begin
                    step_next = ctrl.target;
                end
            end
            fcw_pkg::BR_BAD:
            begin
                if (cur_reg < fcw_pkg::FIRST_DATA_CLUSTER)
                begin
                    out_next = '{cluster: cur_reg, sector_lba: 24'd0, last: 1'b1,
                                 status: fcw_pkg::ST_BAD};
                    if (slot_free)
                    begin
                        emit      = 1'b1;
                        step_next = fcw_pkg::S_IDLE;
                    end
                end
                else
                begin
                    step_next = ctrl.target;
                end
            end
            fcw_pkg::BR_NEXT:
            begin
                step_next = ctrl.target;
            end
            fcw_pkg::BR_LINK:
            begin
                if (next_cl >= end_thr_reg)
                begin
                    out_next = '{cluster: cur_reg, sector_lba: lba, last: 1'b1,
                                 status: fcw_pkg::ST_OK};
                end
                else if (cnt_reg == fcw_pkg::CNT_W'(fcw_pkg::MAX_CHAIN - 1))
                begin
                    out_next = '{cluster: cur_reg, sector_lba: lba, last: 1'b1,
                                 status: fcw_pkg::ST_LONG};
                end
                else
                begin
                    out_next = '{cluster: cur_reg, sector_lba: lba, last: 1'b0,
                                 status: fcw_pkg::ST_OK};
                end
                if (slot_free)
                begin
                    emit = 1'b1;
                    if (out_next.last)
                    begin
                        step_next = fcw_pkg::S_IDLE;
                    end
                    else
                    begin
                        cur_next  = next_cl;
                        cnt_next  = cnt_reg + fcw_pkg::CNT_W'(1);
                        step_next = ctrl.target;
                    end
                end
            end
            default:
            begin
                step_next = fcw_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= fcw_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        if (emit)
        begin
            out_reg <= out_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // A new result is only loaded when the previous one is gone or leaves now.
    `FCW_ASSERT_IMPL(a_emit_slot_free, emit, (!out_valid_reg || result_ready))
    // The link step is reached only from the low-byte step or by stalling in place.
    `FCW_ASSERT_IMPL(a_link_order, (step_reg == fcw_pkg::S_LINK),
        ($past(step_reg) == fcw_pkg::S_LO || $past(step_reg) == fcw_pkg::S_LINK))
    // The final result of a walk returns the sequencer to accepting items.
    `FCW_ASSERT_NEXT(a_last_ends_walk, (emit && out_next.last), item_ready)

endmodule
`default_nettype wire

// ===== sim/tb_fat12_cluster_chain_walker.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the FAT12 cluster chain walker: builds FAT chains
// through write transfers, walks them and checks every visit against a predictor.
// Depends on fcw_pkg and the fat12_cluster_chain_walker RTL.
module tb_fat12_cluster_chain_walker;

    localparam int          HALF_PERIOD  = 6;
    localparam int          DRAIN_CYCLES = 20;
    localparam logic [11:0] END_MARK     = 12'hFFF;

    // Predicts the visits of each walk from its own copy of the FAT and registers.
    class chain_checker;
        logic [7:0]       fat [fcw_pkg::FAT_BYTES];
        logic [15:0]      data_start;
        logic [7:0]       spc;
        logic [11:0]      thr;
        fcw_pkg::result_t visits_due [$];
        int               errors;

        function new();
            data_start = 16'd33;
            spc        = 8'd1;
            thr        = 12'd4088;
            errors     = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] val);
            case (idx)
                fcw_pkg::REG_DATA_START: data_start = val[15:0];
                fcw_pkg::REG_SPC:        spc        = val[7:0];
                fcw_pkg::REG_END_THR:    thr        = val[11:0];
                default:                 ;
            endcase
        endfunction

        function logic [11:0] fat_entry(logic [11:0] c);
            logic [12:0] off;
            logic [15:0] pair;
            off  = 13'(c) + 13'(c >> 1);
            pair = {fat[off + 13'd1], fat[off]};
            return c[0] ? pair[15:4] : pair[11:0];
        endfunction

        function void push_visit(logic [11:0] c, logic [23:0] lba, logic last,
                                 logic [1:0] status);
            fcw_pkg::result_t r;
            r.cluster    = c;
            r.sector_lba = lba;
            r.last       = last;
            r.status     = status;
            visits_due.push_back(r);
        endfunction

        function void take_item(fcw_pkg::item_t it);
            logic [11:0] c;
            logic [11:0] nx;
            logic [23:0] lba;
            if (it.operation == fcw_pkg::OP_WRITE)
            begin
                fat[it.fat_address] = it.fat_byte;
                return;
            end
            c = it.start_cluster;
            if (c >= thr)
            begin
                push_visit(c, 24'd0, 1'b1, fcw_pkg::ST_EMPTY);
                return;
            end
            for (int n = 0; n < fcw_pkg::MAX_CHAIN; n++)
            begin
                if (c < fcw_pkg::FIRST_DATA_CLUSTER)
                begin
                    push_visit(c, 24'd0, 1'b1, fcw_pkg::ST_BAD);
                    return;
                end
                lba = 24'(data_start) + 24'(c - fcw_pkg::FIRST_DATA_CLUSTER) * 24'(spc);
                nx  = fat_entry(c);
                if (nx >= thr)
                begin
                    push_visit(c, lba, 1'b1, fcw_pkg::ST_OK);
                    return;
                end
                if (n + 1 >= fcw_pkg::MAX_CHAIN)
                begin
                    push_visit(c, lba, 1'b1, fcw_pkg::ST_LONG);
                    return;
                end
                push_visit(c, lba, 1'b0, fcw_pkg::ST_OK);
                c = nx;
            end
        endfunction

        function void compare(string name, logic [23:0] want, logic [23:0] got);
            if (got !== want)
            begin
                $error("%s: expected %0d, actual %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_visit(fcw_pkg::result_t r);
            fcw_pkg::result_t want;
            if (visits_due.size() == 0)
            begin
                $error("unexpected result transfer: cluster %0d", r.cluster);
                errors++;
                return;
            end
            want = visits_due.pop_front();
            compare("cluster", 24'(want.cluster), 24'(r.cluster));
            compare("sector_lba", want.sector_lba, r.sector_lba);
            compare("last", 24'(want.last), 24'(r.last));
            compare("status", 24'(want.status), 24'(r.status));
        endfunction

        function int pending();
            return visits_due.size();
        endfunction
    endclass

    logic             clk          = 1'b0;
    logic             rst_n        = 1'b0;
    logic             item_valid   = 1'b0;
    logic             item_ready;
    fcw_pkg::item_t   item         = '0;
    logic             result_valid;
    logic             result_ready = 1'b0;
    fcw_pkg::result_t result;
    logic             psel         = 1'b0;
    logic             penable      = 1'b0;
    logic             pwrite       = 1'b0;
    logic [3:0]       paddr        = '0;
    logic [31:0]      pwdata       = '0;
    logic [31:0]      prdata;
    logic             pready;

    chain_checker sb = new();

    // What the stimulus side knows of the FAT, kept so no walk reads an unwritten byte.
    logic [7:0] plan_fat [fcw_pkg::FAT_BYTES];
    bit         plan_written [fcw_pkg::FAT_BYTES];

    int send_pct  = 0;
    int stall_pct = 0;
    int sent      = 0;

    fat12_cluster_chain_walker u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #(HALF_PERIOD) clk = ~clk;

    always @(posedge clk)
    begin
        result_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && item_valid && item_ready)
            sb.take_item(item);
        if (rst_n && result_valid && result_ready)
            sb.check_visit(result);
    end

    // This task lowers valid only when a gap is taken, so back-to-back transfers keep it high.
    task automatic send_item(fcw_pkg::item_t it);
        while ($urandom_range(99) < send_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        do @(posedge clk); while (!item_ready);
        sent++;
    endtask

    task automatic write_byte(logic [12:0] addr, logic [7:0] data);
        fcw_pkg::item_t it;
        it.operation     = fcw_pkg::OP_WRITE;
        it.fat_address   = addr;
        it.fat_byte      = data;
        it.start_cluster = 12'($urandom);
        plan_fat[addr]     = data;
        plan_written[addr] = 1'b1;
        send_item(it);
    endtask

    task automatic walk(logic [11:0] start);
        fcw_pkg::item_t it;
        it.operation     = fcw_pkg::OP_WALK;
        it.fat_address   = 13'($urandom);
        it.fat_byte      = 8'($urandom);
        it.start_cluster = start;
        send_item(it);
    endtask

    // Writes one 12-bit entry; the nibble shared with the neighbor entry is kept.
    task automatic set_entry(logic [11:0] c, logic [11:0] val);
        logic [12:0] off;
        logic [7:0]  keep;
        off = 13'(c) + 13'(c >> 1);
        if (!c[0])
        begin
            keep = plan_written[off + 13'd1] ? plan_fat[off + 13'd1] : 8'($urandom);
            write_byte(off, val[7:0]);
            write_byte(off + 13'd1, {keep[7:4], val[11:8]});
        end
        else
        begin
            keep = plan_written[off] ? plan_fat[off] : 8'($urandom);
            write_byte(off, {val[3:0], keep[3:0]});
            write_byte(off + 13'd1, val[11:4]);
        end
    endtask

    function automatic bit walk_is_safe(logic [11:0] start);
        logic [11:0] c;
        logic [12:0] off;
        logic [15:0] pair;
        c = start;
        if (c >= sb.thr)
            return 1'b1;
        for (int n = 0; n < fcw_pkg::MAX_CHAIN; n++)
        begin
            if (c < fcw_pkg::FIRST_DATA_CLUSTER)
                return 1'b1;
            off = 13'(c) + 13'(c >> 1);
            if (!plan_written[off] || !plan_written[off + 13'd1])
                return 1'b0;
            pair = {plan_fat[off + 13'd1], plan_fat[off]};
            c = c[0] ? pair[15:4] : pair[11:0];
            if (c >= sb.thr)
                return 1'b1;
        end
        return 1'b1;
    endfunction

    // Valid drops and the clock runs on before the pending check, so the predictor has seen the last input transfer.
    task automatic wait_idle();
        item_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic apb_write(logic [1:0] idx, logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        sb.set_reg(idx, val);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_config(logic [15:0] ds, logic [7:0] spc, logic [11:0] thr);
        wait_idle();
        apb_write(fcw_pkg::REG_DATA_START, 32'(ds));
        apb_write(fcw_pkg::REG_SPC, 32'(spc));
        apb_write(fcw_pkg::REG_END_THR, 32'(thr));
    endtask

    // A chain of random clusters ended by an end marker, a bad cluster, a loop
    // back to its head, or a link into whatever the FAT already holds.
    task automatic build_and_walk();
        logic [11:0] nodes [6];
        logic [11:0] term;
        int          len;
        int          kind;
        int          top;
        if (sb.thr < 3)
        begin
            walk(12'($urandom_range(4095)));
            return;
        end
        top = int'(sb.thr) - 1;
        len = $urandom_range(6, 1);
        for (int i = 0; i < len; i++)
            nodes[i] = 12'($urandom_range(top, 2));
        kind = $urandom_range(5);
        case (kind)
            0, 1, 2: term = 12'($urandom_range(4095, int'(sb.thr)));
            3:       term = 12'($urandom_range(1, 0));
            4:       term = nodes[0];
            default: term = 12'($urandom_range(top, 2));
        endcase
        for (int i = 0; i < len - 1; i++)
            set_entry(nodes[i], nodes[i + 1]);
        set_entry(nodes[len - 1], term);
        if (!walk_is_safe(nodes[0]))
            set_entry(nodes[len - 1], END_MARK);
        if (walk_is_safe(nodes[0]))
            walk(nodes[0]);
        if ($urandom_range(5) == 0)
            wait_idle();
    endtask

    task automatic random_step();
        int          pick;
        logic [11:0] start;
        pick = $urandom_range(99);
        if (pick < 55)
            build_and_walk();
        else if (pick < 75)
            write_byte(13'($urandom), 8'($urandom));
        else
        begin
            start = 12'($urandom_range(4095));
            if (walk_is_safe(start))
                walk(start);
            else
                walk(12'($urandom_range(1, 0)));
        end
    endtask

    task automatic run_phase(logic [15:0] ds, logic [7:0] spc, logic [11:0] thr,
                             int send_p, int stall_p, int count);
        int first;
        set_config(ds, spc, thr);
        send_pct  = send_p;
        stall_pct = stall_p;
        first     = sent;
        while (sent - first < count)
            random_step();
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset register values: bad starts, empty starts at and above the threshold.
        walk(12'd0);
        walk(12'd1);
        walk(12'd4095);
        walk(12'd4088);
        write_byte(13'd0, 8'h00);
        write_byte(13'd8191, 8'hFF);
        // Short chain ending on the all-ones marker.
        set_entry(12'd2, 12'd3);
        set_entry(12'd3, 12'd4);
        set_entry(12'd4, END_MARK);
        walk(12'd2);
        // A cluster that links to itself runs until the chain is too long.
        set_entry(12'd4087, 12'd4087);
        walk(12'd4087);
        // A bad cluster met in the middle of a chain.
        set_entry(12'd5, 12'd1);
        walk(12'd5);
        // A link exactly at the threshold ends the chain.
        set_entry(12'd6, 12'd4088);
        walk(12'd6);

        run_phase(16'hFFFF, 8'd128, 12'd4095, 74, 0, 35);
        run_phase(16'($urandom), 8'($urandom_range(128, 1)),
                  12'($urandom_range(4095, 100)), 0, 74, 35);
        run_phase(16'd0, 8'd128, 12'd2000, 7, 7, 35);
        run_phase(16'($urandom), 8'd1, 12'd0, 0, 0, 20);
        run_phase(16'd0, 8'd1, 12'd1, 7, 7, 10);
        run_phase(16'hFFFF, 8'd64, 12'd4088, 0, 0, 35);

        wait_idle();
        if (sb.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/fcw_pkg.sv
rtl/fat12_cluster_chain_walker.sv
sim/tb_fat12_cluster_chain_walker.sv
